// ----- rtl/sfbm_pkg.sv -----
// package for the stereo frame fifo with block meter
// holds sizes, beat structs, the controller state type and the command/status structs
// no dependencies
package sfbm_pkg;

  localparam int RING_FRAMES = 2048;
  localparam int BLOCK_SIZE  = 64;   // power of two: the mean is a shift

  localparam int PTR_W      = $clog2(RING_FRAMES);
  localparam int SAMPLE_W   = 16;
  localparam int FILL_W     = 11;
  localparam int METER_W    = 16;
  localparam int MAG_W      = SAMPLE_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int BLOCK_LOG2 = $clog2(BLOCK_SIZE);
  localparam int SUM_W      = SQ_W + BLOCK_LOG2;
  localparam int CNT_W      = (BLOCK_LOG2 > 0) ? BLOCK_LOG2 : 1;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

  localparam logic ACT_PUSH   = 1'b0;
  localparam logic ACT_TICK   = 1'b1;
  localparam logic ROOT_LEFT  = 1'b0;
  localparam logic ROOT_RIGHT = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       underrun;
    logic                       push_refused;
    logic [FILL_W-1:0]          fill_frames;
    logic                       block_done;
    logic [METER_W-1:0]         rms_left;
    logic [METER_W-1:0]         rms_right;
    logic [METER_W-1:0]         peak_left;
    logic [METER_W-1:0]         peak_right;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_TICK,
    S_ACC,
    S_ROOT_L,
    S_WAIT_L,
    S_ROOT_R,
    S_WAIT_R,
    S_CLOSE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic do_push;
    logic do_tick;
    logic root_go;
    logic root_sel;
    logic cap_l;
    logic cap_r;
    logic close;
    logic emit;
    logic emit_held;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic closing;
    logic root_busy;
  } dp_status_t;

endpackage

// ----- rtl/sfbm_isqrt.sv -----
// integer square root, one result bit per cycle (restoring digit recurrence)
// uses sfbm_pkg for widths
module sfbm_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sfbm_pkg::SQ_W-1:0] radicand,
  output logic                      busy,
  output logic [sfbm_pkg::ROOT_W-1:0] root
);
  import sfbm_pkg::*;

  logic [ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SQ_W-1:0]       rad_r, rad_nxt;
  logic [ROOT_W:0]       rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [ROOT_W+2:0]     rem_sh;
  logic [ROOT_W+2:0]     trial;
  logic [ROOT_W+2:0]     diff;

  always_comb begin
    rem_sh   = {rem_r, rad_r[SQ_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = rem_sh - trial;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      cnt_nxt  = ROOT_CNT_W'(ROOT_W);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      rad_nxt = {rad_r[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = diff[ROOT_W:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[ROOT_W:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = (cnt_r != '0);
  assign root = root_r;

endmodule

// ----- rtl/sfbm_dp.sv -----
// datapath: frame ring, pointers, square/peak accumulators, meters and the output register
// uses sfbm_pkg and instantiates sfbm_isqrt
module sfbm_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sfbm_pkg::ctrl_cmd_t    cmd,
  output sfbm_pkg::dp_status_t   status,
  input  sfbm_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sfbm_pkg::out_item_t    out_data
);
  import sfbm_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_FRAMES - 1);
  localparam logic [CNT_W-1:0] TICK_LAST = CNT_W'(BLOCK_SIZE - 1);

  logic [2*SAMPLE_W-1:0] mem [RING_FRAMES];
  logic [2*SAMPLE_W-1:0] rd_data_r;

  in_item_t  item_r;
  logic [PTR_W-1:0] wp_r, rp_r, count_r, count_nxt;
  logic [CNT_W-1:0] tick_cnt_r;
  logic [SQ_W-1:0]  sq_l_r, sq_r_r;
  logic             acc_en_r;
  logic [SUM_W-1:0] sum_l_r, sum_r_r;
  logic [METER_W-1:0] pk_l_r, pk_r_r;
  logic [METER_W-1:0] run_pk_l_r, run_pk_r_r;
  logic [METER_W-1:0] rms_l_r, rms_r_r;
  logic [METER_W-1:0] blk_rms_l_r, blk_rms_r_r;
  out_item_t hold_r, now_res, emit_res, out_r;
  logic      out_valid_r;

  logic full, empty, is_tick, wr_en;
  logic [SAMPLE_W-1:0] u_l, u_r;
  logic [MAG_W-1:0]    mag_l, mag_r;
  logic [SQ_W-1:0]     sq_l_nxt, sq_r_nxt;
  logic [PTR_W+FILL_W-1:0] fill_ext;
  logic [SQ_W-1:0]     radicand;
  logic                root_busy;
  logic [ROOT_W-1:0]   root_val;

  assign full    = (count_r == PTR_LAST);
  assign empty   = (count_r == '0);
  assign is_tick = (item_r.action == ACT_TICK);
  assign wr_en   = cmd.do_push && !full;

  always_comb begin
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.do_tick && !empty) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // popped frame or silence
  assign u_l = empty ? '0 : rd_data_r[SAMPLE_W-1:0];
  assign u_r = empty ? '0 : rd_data_r[2*SAMPLE_W-1:SAMPLE_W];
  assign mag_l = u_l[SAMPLE_W-1] ? (~u_l + 1'b1) : u_l;
  assign mag_r = u_r[SAMPLE_W-1] ? (~u_r + 1'b1) : u_r;
  assign sq_l_nxt = mag_l * mag_l;
  assign sq_r_nxt = mag_r * mag_r;

  assign fill_ext = {{FILL_W{1'b0}}, count_nxt};

  always_comb begin
    now_res              = '0;
    now_res.fill_frames  = fill_ext[FILL_W-1:0];
    if (is_tick) begin
      now_res.out_left  = signed'(u_l);
      now_res.out_right = signed'(u_r);
      now_res.underrun  = empty;
    end else begin
      now_res.push_refused = full;
    end
  end

  always_comb begin
    emit_res            = cmd.emit_held ? hold_r : now_res;
    emit_res.block_done = cmd.emit_held;
    emit_res.rms_left   = rms_l_r;
    emit_res.rms_right  = rms_r_r;
    emit_res.peak_left  = pk_l_r;
    emit_res.peak_right = pk_r_r;
  end

  assign radicand = (cmd.root_sel == ROOT_RIGHT) ? sum_r_r[SUM_W-1:BLOCK_LOG2]
                                                 : sum_l_r[SUM_W-1:BLOCK_LOG2];

  sfbm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_go),
    .radicand (radicand),
    .busy     (root_busy),
    .root     (root_val)
  );

  // ring store, read every cycle at the read pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= {item_r.right_sample, item_r.left_sample};
    end
    rd_data_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      count_r     <= '0;
      tick_cnt_r  <= '0;
      acc_en_r    <= 1'b0;
      sum_l_r     <= '0;
      sum_r_r     <= '0;
      run_pk_l_r  <= '0;
      run_pk_r_r  <= '0;
      rms_l_r     <= '0;
      rms_r_r     <= '0;
      pk_l_r      <= '0;
      pk_r_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      acc_en_r <= cmd.do_tick;
      if (wr_en) begin
        wp_r <= (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
      end
      if (cmd.do_tick && !empty) begin
        rp_r <= (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
      end
      if (cmd.do_tick) begin
        if (tick_cnt_r != TICK_LAST) begin
          tick_cnt_r <= tick_cnt_r + 1'b1;
        end
        if (mag_l > run_pk_l_r) begin
          run_pk_l_r <= mag_l;
        end
        if (mag_r > run_pk_r_r) begin
          run_pk_r_r <= mag_r;
        end
      end
      // squares are added to the sums in the cycle after the tick
      if (acc_en_r) begin
        sum_l_r <= sum_l_r + SUM_W'(sq_l_r);
        sum_r_r <= sum_r_r + SUM_W'(sq_r_r);
      end
      if (cmd.close) begin
        rms_l_r    <= blk_rms_l_r;
        rms_r_r    <= blk_rms_r_r;
        pk_l_r     <= run_pk_l_r;
        pk_r_r     <= run_pk_r_r;
        tick_cnt_r <= '0;
        sum_l_r    <= '0;
        sum_r_r    <= '0;
        run_pk_l_r <= '0;
        run_pk_r_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.do_tick) begin
      sq_l_r <= sq_l_nxt;
      sq_r_r <= sq_r_nxt;
    end
    if (cmd.do_push || cmd.do_tick) begin
      hold_r <= now_res;
    end
    if (cmd.cap_l) begin
      blk_rms_l_r <= METER_W'(root_val);
    end
    if (cmd.cap_r) begin
      blk_rms_r_r <= METER_W'(root_val);
    end
    if (cmd.emit) begin
      out_r <= emit_res;
    end
  end

  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.closing   = (tick_cnt_r == TICK_LAST);
  assign status.root_busy = root_busy;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_refused_keeps_wp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_push && full |=> $stable(wp_r))
    else $error("refused push moved the write pointer");

  a_underrun_keeps_rp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_tick && empty |=> $stable(rp_r))
    else $error("underrun tick moved the read pointer");

  a_close_at_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.close |-> tick_cnt_r == TICK_LAST)
    else $error("meters closed before the block was complete");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result overwrote a beat still waiting at the output");

endmodule

// ----- rtl/sfbm_ctrl.sv -----
// controller state machine: sequences push, tick, block close and result beats
// uses sfbm_pkg for the state type and the command/status structs
module sfbm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_stall,
  input  sfbm_pkg::dp_status_t status,
  output sfbm_pkg::ctrl_cmd_t  cmd
);
  import sfbm_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == ACT_TICK) ? S_TICK : S_PUSH;
        end
      end
      S_PUSH: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (status.closing) begin
          state_nxt = S_ACC;
        end else if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_ACC:    state_nxt = S_ROOT_L;
      S_ROOT_L: state_nxt = S_WAIT_L;
      S_WAIT_L: begin
        if (!status.root_busy) begin
          state_nxt = S_ROOT_R;
        end
      end
      S_ROOT_R: state_nxt = S_WAIT_R;
      S_WAIT_R: begin
        if (!status.root_busy) begin
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.accept = in_valid;
      S_PUSH: begin
        cmd.do_push = status.out_free;
        cmd.emit    = status.out_free;
      end
      S_TICK: begin
        // the closing tick is taken at once, its beat goes out after the roots
        cmd.do_tick = status.closing || status.out_free;
        cmd.emit    = !status.closing && status.out_free;
      end
      S_ROOT_L: begin
        cmd.root_go  = 1'b1;
        cmd.root_sel = ROOT_LEFT;
      end
      S_WAIT_L: cmd.cap_l = !status.root_busy;
      S_ROOT_R: begin
        cmd.root_go  = 1'b1;
        cmd.root_sel = ROOT_RIGHT;
      end
      S_WAIT_R: cmd.cap_r = !status.root_busy;
      S_CLOSE:  cmd.close = 1'b1;
      S_EMIT: begin
        cmd.emit      = status.out_free;
        cmd.emit_held = 1'b1;
      end
      default:  cmd = '0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/stereo_frame_fifo_with_block_meter_top.sv -----
// top level of the stereo frame fifo with block meter
// uses sfbm_pkg, instantiates sfbm_ctrl and sfbm_dp
//
//   channel   signals                    beat
//   input     in_valid  in_stall  in_data    in_item_t: action, left/right sample
//   result    out_valid out_stall out_data   out_item_t: samples, flags, fill, meters
//
// a push or an ordinary tick passes the accept step, then the ring write or the
// registered ring read feeding the result register
// a tick that closes a block waits on the shared root unit, which makes one result
// bit per cycle, left channel then right
// synchronous active-low reset clears pointers, sums, peaks and meters; ring contents
// stay undefined and need no clearing
// a result beat waits in the output register while the next item is taken; an item
// finishes only once that register is free
module stereo_frame_fifo_with_block_meter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfbm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sfbm_pkg::out_item_t out_data
);
  import sfbm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sfbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sfbm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
